>>> hdl/bgp_pkg.sv
// ============================================================================
// bgp_pkg
// Shared types and constants of the bilinear gradient pixel generator.
// ============================================================================
package bgp_pkg;

    localparam int MAX_DIM = 4096;

    localparam logic [2:0] REG_TOP_LEFT     = 3'd0;
    localparam logic [2:0] REG_TOP_RIGHT    = 3'd1;
    localparam logic [2:0] REG_BOTTOM_LEFT  = 3'd2;
    localparam logic [2:0] REG_BOTTOM_RIGHT = 3'd3;
    localparam logic [2:0] REG_RECT_WIDTH   = 3'd4;
    localparam logic [2:0] REG_RECT_HEIGHT  = 3'd5;

    // Register stages of one interpolation, from the head register to the result register.
    localparam int LERP_LATENCY = 10;

    typedef struct packed {
        logic [11:0] pix_x;
        logic [11:0] pix_y;
    } in_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       drawn;
    } out_t;

    typedef struct packed {
        logic [19:0] rem;
        logic [18:0] dsh;
        logic [7:0]  quo;
        logic [7:0]  base;
        logic        neg;
    } div_t;

endpackage

>>> hdl/bilinear_gradient_pixel.sv
// ============================================================================
// bilinear_gradient_pixel
// Bilinear RGB gradient over a configured rectangle, one pixel per clock.
// ============================================================================
// The block takes one pixel beat per clock and presents its color through
// twenty register stages: two interpolations in a row, each a multiply stage,
// a row of eight division cells and a result register. The whole pipeline
// advances together and halts only while a finished result is stalled at the
// output. The configuration port is always ready; write registers only while
// idle.
module bilinear_gradient_pixel (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  bgp_pkg::in_t  in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output bgp_pkg::out_t out_data,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data
);
    import bgp_pkg::*;

    localparam int DEPTH = 2 * LERP_LATENCY;

    logic [23:0] tl_reg, tr_reg, bl_reg, br_reg;
    logic [12:0] width_reg, height_reg;
    logic        advance;
    logic        ok;
    logic [11:0] pos_x, span_x, py_in, hm1_in;
    logic [23:0] tl_g, tr_g, bl_g, br_g;
    logic [DEPTH-1:0] valid_reg;
    logic [DEPTH-1:0] drawn_reg;
    logic [11:0] py_reg  [0:LERP_LATENCY-1];
    logic [11:0] hm1_reg [0:LERP_LATENCY-1];
    logic [7:0]  top_val [0:2];
    logic [7:0]  bot_val [0:2];
    logic [7:0]  pix_val [0:2];

    assign cfg_ready = 1'b1;
    assign advance   = !(valid_reg[DEPTH-1] && out_stall);
    assign in_stall  = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tl_reg     <= '0;
            tr_reg     <= '0;
            bl_reg     <= '0;
            br_reg     <= '0;
            width_reg  <= 13'd2;
            height_reg <= 13'd2;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_TOP_LEFT:     tl_reg     <= cfg_data;
                REG_TOP_RIGHT:    tr_reg     <= cfg_data;
                REG_BOTTOM_LEFT:  bl_reg     <= cfg_data;
                REG_BOTTOM_RIGHT: br_reg     <= cfg_data;
                REG_RECT_WIDTH:   width_reg  <= cfg_data[12:0];
                REG_RECT_HEIGHT:  height_reg <= cfg_data[12:0];
                default:          ;
            endcase
        end
    end

    // An invalid pixel runs through with zero corners, which yields zero color.
    always_comb
    begin
        ok = width_reg > 13'd1 && height_reg > 13'd1
          && width_reg <= 13'(MAX_DIM) && height_reg <= 13'(MAX_DIM)
          && {1'b0, in_data.pix_x} < width_reg
          && {1'b0, in_data.pix_y} < height_reg;
        tl_g   = ok ? tl_reg : '0;
        tr_g   = ok ? tr_reg : '0;
        bl_g   = ok ? bl_reg : '0;
        br_g   = ok ? br_reg : '0;
        pos_x  = ok ? in_data.pix_x : '0;
        py_in  = ok ? in_data.pix_y : '0;
        span_x = ok ? 12'(width_reg - 13'd1) : 12'd1;
        hm1_in = ok ? 12'(height_reg - 13'd1) : 12'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (advance)
        begin
            valid_reg <= {valid_reg[DEPTH-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            drawn_reg  <= {drawn_reg[DEPTH-2:0], ok};
            py_reg[0]  <= py_in;
            hm1_reg[0] <= hm1_in;
            for (int i = 1; i < LERP_LATENCY; i++)
            begin
                py_reg[i]  <= py_reg[i-1];
                hm1_reg[i] <= hm1_reg[i-1];
            end
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        bgp_lerp u_top (
            .clk (clk), .en (advance),
            .a (tl_g[c*8 +: 8]), .b (tr_g[c*8 +: 8]),
            .pos (pos_x), .span (span_x), .result (top_val[c])
        );
        bgp_lerp u_bot (
            .clk (clk), .en (advance),
            .a (bl_g[c*8 +: 8]), .b (br_g[c*8 +: 8]),
            .pos (pos_x), .span (span_x), .result (bot_val[c])
        );
        bgp_lerp u_mid (
            .clk (clk), .en (advance),
            .a (top_val[c]), .b (bot_val[c]),
            .pos (py_reg[LERP_LATENCY-1]), .span (hm1_reg[LERP_LATENCY-1]),
            .result (pix_val[c])
        );
    end

    assign out_valid      = valid_reg[DEPTH-1];
    assign out_data.red   = pix_val[2];
    assign out_data.green = pix_val[1];
    assign out_data.blue  = pix_val[0];
    assign out_data.drawn = drawn_reg[DEPTH-1];

    a_blank_when_not_drawn: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_data.drawn) |->
            (out_data.red == 8'd0 && out_data.green == 8'd0 && out_data.blue == 8'd0))
        else $error("pixel not drawn but color is not zero");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("input stalled without a held result");

    a_pipe_holds: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |=> $stable(valid_reg))
        else $error("pipeline moved while halted");
endmodule

>>> hdl/bgp_div_cell.sv
// ============================================================================
// bgp_div_cell
// One restoring division step; the divisor moves one place right per cell.
// ============================================================================
module bgp_div_cell (
    input  logic         clk,
    input  logic         en,
    input  bgp_pkg::div_t din,
    output bgp_pkg::div_t dout
);
    import bgp_pkg::*;

    logic  ge;
    div_t  dout_reg;
    div_t  dout_next;

    always_comb
    begin
        ge = din.rem >= {1'b0, din.dsh};
        dout_next      = din;
        dout_next.rem  = ge ? din.rem - {1'b0, din.dsh} : din.rem;
        dout_next.dsh  = din.dsh >> 1;
        dout_next.quo  = {din.quo[6:0], ge};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dout_reg <= dout_next;
        end
    end

    assign dout = dout_reg;
endmodule

>>> hdl/bgp_lerp.sv
// ============================================================================
// bgp_lerp
// Pipelined a + pos*(b-a)/span with truncation toward zero, through a row
// of eight division cells.
// ============================================================================
module bgp_lerp (
    input  logic        clk,
    input  logic        en,
    input  logic [7:0]  a,
    input  logic [7:0]  b,
    input  logic [11:0] pos,
    input  logic [11:0] span,
    output logic [7:0]  result
);
    import bgp_pkg::*;

    logic [7:0] mag;
    div_t       head_reg;
    div_t       head_next;
    div_t       chain [0:8];
    logic [7:0] result_reg;
    logic [7:0] result_next;

    always_comb
    begin
        mag = (b >= a) ? b - a : a - b;
        head_next.rem  = 20'(pos) * 20'(mag);
        head_next.dsh  = {span, 7'b0};
        head_next.quo  = '0;
        head_next.base = a;
        head_next.neg  = b < a;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    for (genvar i = 0; i < 8; i++)
    begin : g_cell
        bgp_div_cell u_cell (
            .clk  (clk),
            .en   (en),
            .din  (chain[i]),
            .dout (chain[i+1])
        );
    end

    assign result_next = chain[8].neg ? chain[8].base - chain[8].quo
                                      : chain[8].base + chain[8].quo;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;
endmodule

>>> sim/gradient_checker.sv
`timescale 1ns / 1ps
// ============================================================================
// gradient_checker
// Watches the pixel and color channels of the gradient generator and the
// register writes, predicts each pixel color and compares it field by field.
// ============================================================================
module gradient_checker (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    input  logic          in_stall,
    input  bgp_pkg::in_t  in_data,
    input  logic          out_valid,
    input  logic          out_stall,
    input  bgp_pkg::out_t out_data,
    input  logic          cfg_valid,
    input  logic          cfg_ready,
    input  logic [2:0]    cfg_index,
    input  logic [23:0]   cfg_data,
    output int            fail_count,
    output int            pending
);
    import bgp_pkg::*;

    logic [23:0] corner_tl, corner_tr, corner_bl, corner_br;
    logic [12:0] width_q, height_q;
    out_t        color_queue[$];

    function automatic int blend(int a, int b, int pos, int span);
        return a + (pos * (b - a)) / span;
    endfunction

    function automatic logic [7:0] channel_color(int sh, int x, int y);
        int top_v;
        int bot_v;
        top_v = blend(int'((corner_tl >> sh) & 8'hFF), int'((corner_tr >> sh) & 8'hFF),
                      x, int'(width_q) - 1);
        bot_v = blend(int'((corner_bl >> sh) & 8'hFF), int'((corner_br >> sh) & 8'hFF),
                      x, int'(width_q) - 1);
        return 8'(blend(top_v, bot_v, y, int'(height_q) - 1));
    endfunction

    function automatic out_t pixel_color(in_t p);
        out_t r;
        r = '0;
        if (width_q > 1 && height_q > 1 && width_q <= MAX_DIM && height_q <= MAX_DIM
            && p.pix_x < width_q && p.pix_y < height_q)
        begin
            r.red   = channel_color(16, int'(p.pix_x), int'(p.pix_y));
            r.green = channel_color(8, int'(p.pix_x), int'(p.pix_y));
            r.blue  = channel_color(0, int'(p.pix_x), int'(p.pix_y));
            r.drawn = 1'b1;
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_t e;
        if (!rst_n)
        begin
            corner_tl = '0;
            corner_tr = '0;
            corner_bl = '0;
            corner_br = '0;
            width_q = 13'd2;
            height_q = 13'd2;
            fail_count = 0;
            color_queue.delete();
            pending = 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (color_queue.size() == 0)
                begin
                    $error("color beat with no pixel waiting");
                    fail_count++;
                end
                else
                begin
                    e = color_queue.pop_front();
                    if (out_data.red !== e.red)
                    begin
                        $error("red expected %0d actual %0d", e.red, out_data.red);
                        fail_count++;
                    end
                    if (out_data.green !== e.green)
                    begin
                        $error("green expected %0d actual %0d", e.green, out_data.green);
                        fail_count++;
                    end
                    if (out_data.blue !== e.blue)
                    begin
                        $error("blue expected %0d actual %0d", e.blue, out_data.blue);
                        fail_count++;
                    end
                    if (out_data.drawn !== e.drawn)
                    begin
                        $error("drawn expected %0d actual %0d", e.drawn, out_data.drawn);
                        fail_count++;
                    end
                end
            end
            if (in_valid && !in_stall)
                color_queue.push_back(pixel_color(in_data));
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_TOP_LEFT:     corner_tl = cfg_data;
                    REG_TOP_RIGHT:    corner_tr = cfg_data;
                    REG_BOTTOM_LEFT:  corner_bl = cfg_data;
                    REG_BOTTOM_RIGHT: corner_br = cfg_data;
                    REG_RECT_WIDTH:   width_q = cfg_data[12:0];
                    REG_RECT_HEIGHT:  height_q = cfg_data[12:0];
                    default:          ;
                endcase
            end
            pending = color_queue.size();
        end
    end
endmodule

>>> sim/testbench.sv
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Drives pixel beats and register writes into the gradient generator under
// random idling and a long output hold-off, and reports the checker verdict.
// ============================================================================
module testbench;
    import bgp_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    in_t         in_data = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    out_t        out_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [23:0] cfg_data = '0;
    int          fail_count;
    int          pending;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_off = 1'b0;
    int          cur_w = 2, cur_h = 2;

    always #4 clk = ~clk;

    bilinear_gradient_pixel u_dut (.*);

    gradient_checker u_checker (.*);

    always @(negedge clk)
    begin
        if (hold_off)
            out_stall <= 1'b1;
        else
            out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    initial
    begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Every task below starts and ends at a falling edge.
    task automatic write_reg(logic [2:0] idx, logic [23:0] val);
        in_valid  <= 1'b0;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
        if (idx == REG_RECT_WIDTH) cur_w = int'(val[12:0]);
        if (idx == REG_RECT_HEIGHT) cur_h = int'(val[12:0]);
    endtask

    // The beat stays offered after acceptance until the next task replaces it.
    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= '{pix_x: x, pix_y: y};
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic drain_pixels();
        in_valid <= 1'b0;
        while (pending != 0) @(posedge clk);
        repeat (2 * LERP_LATENCY + 10) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic random_pixel();
        int mode;
        mode = $urandom_range(9);
        if (mode < 7 && cur_w > 0 && cur_h > 0)
            send_pixel(12'($urandom_range(cur_w > 4096 ? 4095 : cur_w - 1)),
                       12'($urandom_range(cur_h > 4096 ? 4095 : cur_h - 1)));
        else
            send_pixel(12'($urandom), 12'($urandom));
    endtask

    task automatic random_setup(int dim_max);
        for (int i = 0; i < 4; i++)
            write_reg(i[2:0], 24'($urandom));
        write_reg(REG_RECT_WIDTH, 24'($urandom_range(dim_max, 2)));
        write_reg(REG_RECT_HEIGHT, 24'($urandom_range(dim_max, 2)));
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_pixel(0, 0);
        send_pixel(1, 1);
        drain_pixels();
        write_reg(REG_TOP_LEFT, 24'hFFFFFF);
        write_reg(REG_TOP_RIGHT, 24'h000000);
        write_reg(REG_BOTTOM_LEFT, 24'h00FF00);
        write_reg(REG_BOTTOM_RIGHT, 24'hFF00FF);
        write_reg(REG_RECT_WIDTH, 24'd4096);
        write_reg(REG_RECT_HEIGHT, 24'd4096);
        write_reg(3'd7, 24'h123456);
        send_pixel(0, 0);
        send_pixel(4095, 0);
        send_pixel(0, 4095);
        send_pixel(4095, 4095);
        send_pixel(2047, 1365);
        send_pixel(12'hAAA, 12'h555);
        drain_pixels();
        write_reg(REG_RECT_WIDTH, 24'd4097);
        send_pixel(0, 0);
        send_pixel(100, 100);
        drain_pixels();
        write_reg(REG_RECT_WIDTH, 24'h001FFF);
        write_reg(REG_RECT_HEIGHT, 24'd1);
        send_pixel(1, 0);
        drain_pixels();
        write_reg(REG_RECT_WIDTH, 24'd0);
        write_reg(REG_RECT_HEIGHT, 24'd3);
        send_pixel(0, 0);
        drain_pixels();
        write_reg(REG_RECT_WIDTH, 24'd5);
        write_reg(REG_RECT_HEIGHT, 24'd7);
        send_pixel(4, 6);
        send_pixel(5, 0);
        send_pixel(0, 7);
        send_pixel(12'hFFF, 12'hFFF);
        drain_pixels();

        for (int phase = 0; phase < 12; phase++)
        begin
            send_idle_pct = (phase < 4) ? 34 : (phase < 8) ? 64 : 0;
            recv_idle_pct = (phase < 4) ? 64 : (phase < 8) ? 34 : 0;
            random_setup((phase % 3 == 0) ? 4097 : 40);
            for (int n = 0; n < 80; n++)
                random_pixel();
            if (phase == 9)
            begin
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (120) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    begin
                        for (int n = 0; n < 60; n++)
                            random_pixel();
                        in_valid <= 1'b0;
                    end
                join
            end
            drain_pixels();
        end

        if (fail_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
